### rtl/core/rrjs_pkg.sv
`timescale 1ns / 1ps

package rrjs_pkg;

  localparam int JOB_ID_W   = 5;
  localparam int LEN_W      = 16;
  localparam int SLICE_W    = 8;
  localparam int STATUS_W   = 2;

  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_CREATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RAN     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic             action;
    logic [LEN_W-1:0] job_length;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [JOB_ID_W-1:0] job_id;
    logic [LEN_W-1:0]    remaining_before;
    logic [SLICE_W-1:0]  slice_used;
    logic                finished;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RING,
    S_TABLE
  } state_t;

endpackage

### rtl/core/rrjs_ram.sv
`timescale 1ns / 1ps

module rrjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rrjs_sched.sv
`timescale 1ns / 1ps

module rrjs_sched #(
  parameter int MAX_JOBS    = 32,
  parameter int LENGTH_BITS = 16,
  parameter int SLICE_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  rrjs_pkg::req_t              req,
  output logic                        req_stall,
  input  logic                        out_busy,
  input  logic [rrjs_pkg::SLICE_W-1:0] time_slice,
  output logic                        rsp_load,
  output rrjs_pkg::rsp_t              rsp_data,
  output logic                        tbl_we,
  output logic [$clog2(MAX_JOBS)-1:0] tbl_waddr,
  output logic [LENGTH_BITS-1:0]      tbl_wdata,
  output logic                        tbl_re,
  output logic [$clog2(MAX_JOBS)-1:0] tbl_raddr,
  input  logic [LENGTH_BITS-1:0]      tbl_rdata,
  output logic                        ring_we,
  output logic [$clog2(MAX_JOBS)-1:0] ring_waddr,
  output logic [$clog2(MAX_JOBS)-1:0] ring_wdata,
  output logic                        ring_re,
  output logic [$clog2(MAX_JOBS)-1:0] ring_raddr,
  input  logic [$clog2(MAX_JOBS)-1:0] ring_rdata
);

  import rrjs_pkg::*;

  localparam int ID_W  = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  state_t                 state, state_next;
  logic [CNT_W-1:0]       created, created_next;
  logic [ID_W-1:0]        head, head_next;
  logic [ID_W-1:0]        tail, tail_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   cur_valid, cur_valid_next;
  logic [ID_W-1:0]        cur_job, cur_job_next;
  logic [SLICE_BITS-1:0]  slice, slice_next;

  logic                   accept;
  logic                   full;
  logic [ID_W-1:0]        new_id;
  logic [ID_W-1:0]        head_inc;
  logic [ID_W-1:0]        tail_inc;
  logic [SLICE_BITS-1:0]  quantum_raw;
  logic [SLICE_BITS-1:0]  quantum;
  logic [LENGTH_BITS-1:0] len_in;
  logic                   fin;
  logic [LENGTH_BITS-1:0] rem_dec;

  logic [LENGTH_BITS+LEN_W-1:0]    len_ext;
  logic [SLICE_BITS+SLICE_W-1:0]   ts_ext;
  logic [ID_W+JOB_ID_W-1:0]        new_id_ext;
  logic [ID_W+JOB_ID_W-1:0]        cur_id_ext;
  logic [LENGTH_BITS+LEN_W-1:0]    rem_ext;
  logic [SLICE_BITS+SLICE_W-1:0]   slice_ext;

  assign full     = (created == CNT_W'(MAX_JOBS));
  assign new_id   = created[ID_W-1:0];
  assign head_inc = (head == ID_W'(MAX_JOBS - 1)) ? '0 : head + ID_W'(1);
  assign tail_inc = (tail == ID_W'(MAX_JOBS - 1)) ? '0 : tail + ID_W'(1);

  assign ts_ext      = {{SLICE_BITS{1'b0}}, time_slice};
  assign quantum_raw = ts_ext[SLICE_BITS-1:0];
  assign quantum     = (quantum_raw == '0) ? SLICE_BITS'(1) : quantum_raw;

  assign len_ext = {{LENGTH_BITS{1'b0}}, req.job_length};
  assign len_in  = len_ext[LENGTH_BITS-1:0];

  assign fin     = (tbl_rdata == '0) || (tbl_rdata == LENGTH_BITS'(1));
  assign rem_dec = tbl_rdata - LENGTH_BITS'(1);

  assign new_id_ext = {{JOB_ID_W{1'b0}}, new_id};
  assign cur_id_ext = {{JOB_ID_W{1'b0}}, cur_job};
  assign rem_ext    = {{LEN_W{1'b0}}, tbl_rdata};
  assign slice_ext  = {{SLICE_W{1'b0}}, slice};

  assign req_stall = (state != S_IDLE) || out_busy;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      created   <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cur_valid <= 1'b0;
      cur_job   <= '0;
      slice     <= '0;
    end else begin
      state     <= state_next;
      created   <= created_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      cur_valid <= cur_valid_next;
      cur_job   <= cur_job_next;
      slice     <= slice_next;
    end
  end

  always_comb begin
    state_next     = state;
    created_next   = created;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    cur_valid_next = cur_valid;
    cur_job_next   = cur_job;
    slice_next     = slice;
    tbl_we         = 1'b0;
    tbl_waddr      = cur_job;
    tbl_wdata      = rem_dec;
    tbl_re         = 1'b0;
    tbl_raddr      = cur_job;
    ring_we        = 1'b0;
    ring_waddr     = tail;
    ring_wdata     = cur_job;
    ring_re        = 1'b0;
    ring_raddr     = head;
    rsp_load       = 1'b0;
    rsp_data       = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACT_CREATE) begin
            rsp_load = 1'b1;
            if (full) begin
              rsp_data.status = ST_FULL;
            end else begin
              tbl_we          = 1'b1;
              tbl_waddr       = new_id;
              tbl_wdata       = len_in;
              ring_we         = 1'b1;
              ring_wdata      = new_id;
              tail_next       = tail_inc;
              count_next      = count + CNT_W'(1);
              created_next    = created + CNT_W'(1);
              rsp_data.status = ST_CREATED;
              rsp_data.job_id = new_id_ext[JOB_ID_W-1:0];
            end
          end else if (cur_valid && (slice < quantum)) begin
            slice_next = slice + SLICE_BITS'(1);
            tbl_re     = 1'b1;
            state_next = S_TABLE;
          end else if (cur_valid && (count == '0)) begin
            slice_next = SLICE_BITS'(1);
            tbl_re     = 1'b1;
            state_next = S_TABLE;
          end else if (cur_valid) begin
            ring_we    = 1'b1;
            tail_next  = tail_inc;
            ring_re    = 1'b1;
            head_next  = head_inc;
            slice_next = SLICE_BITS'(1);
            state_next = S_RING;
          end else if (count != '0) begin
            ring_re        = 1'b1;
            head_next      = head_inc;
            count_next     = count - CNT_W'(1);
            slice_next     = SLICE_BITS'(1);
            cur_valid_next = 1'b1;
            state_next     = S_RING;
          end else begin
            slice_next      = '0;
            rsp_load        = 1'b1;
            rsp_data.status = ST_IDLE;
          end
        end
      end
      S_RING: begin
        cur_job_next   = ring_rdata;
        cur_valid_next = 1'b1;
        tbl_re         = 1'b1;
        tbl_raddr      = ring_rdata;
        state_next     = S_TABLE;
      end
      S_TABLE: begin
        tbl_we                    = 1'b1;
        rsp_load                  = 1'b1;
        rsp_data.status           = ST_RAN;
        rsp_data.job_id           = cur_id_ext[JOB_ID_W-1:0];
        rsp_data.remaining_before = rem_ext[LEN_W-1:0];
        rsp_data.slice_used       = slice_ext[SLICE_W-1:0];
        rsp_data.finished         = fin;
        if (fin) begin
          cur_valid_next = 1'b0;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/round_robin_job_scheduler.sv
`timescale 1ns / 1ps

// Round-robin job scheduler with a time slice. A create beat stores the job
// length in the job table, assigns the next id and appends the id to the
// ready ring; it never leaves the idle state, nor do a full-table create
// and an idle tick. A tick that keeps the current job reads the job table,
// then writes back the remaining count. A tick that switches jobs reads the
// ready ring at the head, which must return before the job table is read.
// The job table and the ready ring are each a single-port-write,
// single-port-read RAM with a registered read. The result sits in an output
// register, so a new beat is taken while the previous result drains, but
// not while the output is stalled. time_slice is written through the cfg
// channel (reset 1, zero acts as 1) and takes effect on the next tick.
module round_robin_job_scheduler #(
  parameter int MAX_JOBS    = 32,
  parameter int LENGTH_BITS = 16,
  parameter int SLICE_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  rrjs_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output rrjs_pkg::rsp_t               rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rrjs_pkg::SLICE_W-1:0] cfg_data
);

  import rrjs_pkg::*;

  localparam int ID_W = $clog2(MAX_JOBS);

  logic [SLICE_W-1:0]     time_slice;
  logic                   out_busy;
  logic                   rsp_load;
  rsp_t                   rsp_data;

  logic                   tbl_we;
  logic [ID_W-1:0]        tbl_waddr;
  logic [LENGTH_BITS-1:0] tbl_wdata;
  logic                   tbl_re;
  logic [ID_W-1:0]        tbl_raddr;
  logic [LENGTH_BITS-1:0] tbl_rdata;
  logic                   ring_we;
  logic [ID_W-1:0]        ring_waddr;
  logic [ID_W-1:0]        ring_wdata;
  logic                   ring_re;
  logic [ID_W-1:0]        ring_raddr;
  logic [ID_W-1:0]        ring_rdata;

  assign cfg_ready = 1'b1;
  assign out_busy  = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= SLICE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      time_slice <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_data;
    end
  end

  rrjs_sched #(
    .MAX_JOBS    (MAX_JOBS),
    .LENGTH_BITS (LENGTH_BITS),
    .SLICE_BITS  (SLICE_BITS)
  ) u_sched (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_stall  (req_stall),
    .out_busy   (out_busy),
    .time_slice (time_slice),
    .rsp_load   (rsp_load),
    .rsp_data   (rsp_data),
    .tbl_we     (tbl_we),
    .tbl_waddr  (tbl_waddr),
    .tbl_wdata  (tbl_wdata),
    .tbl_re     (tbl_re),
    .tbl_raddr  (tbl_raddr),
    .tbl_rdata  (tbl_rdata),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_re    (ring_re),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata)
  );

  rrjs_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_JOBS)
  ) u_job_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rrjs_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_JOBS)
  ) u_ready_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule

### sim/tb_round_robin_job_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_job_scheduler;
  import rrjs_pkg::*;

  localparam int          NUM_JOBS    = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          PHASE_ITEMS = 200;
  localparam int          HOLD_CYCLES = 300;

  class sched_scoreboard;
    logic [SLICE_W-1:0]  time_slice;
    logic [LEN_W-1:0]    job_len[NUM_JOBS];
    logic [LEN_W-1:0]    job_prog[NUM_JOBS];
    bit                  job_fin[NUM_JOBS];
    int unsigned         made;
    logic [JOB_ID_W-1:0] ring_ids[NUM_JOBS];
    int unsigned         ring_head, ring_tail, ring_count;
    bit                  cur_valid;
    logic [JOB_ID_W-1:0] cur_job;
    logic [SLICE_W-1:0]  slice_cnt;
    rsp_t                due_results[$];
    int unsigned         errors;

    function new();
      time_slice = 8'd1;
      foreach (job_len[i]) begin
        job_len[i]  = '0;
        job_prog[i] = '0;
        job_fin[i]  = 1'b0;
        ring_ids[i] = '0;
      end
      made       = 0;
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      cur_valid  = 1'b0;
      cur_job    = '0;
      slice_cnt  = '0;
      errors     = 0;
    endfunction

    function void set_slice(logic [SLICE_W-1:0] v);
      time_slice = v;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function int unsigned jobs_made();
      return made;
    endfunction

    function void ring_push(logic [JOB_ID_W-1:0] id);
      if (ring_count >= NUM_JOBS) return;
      ring_ids[ring_tail] = id;
      ring_tail = (ring_tail + 1 >= NUM_JOBS) ? 0 : ring_tail + 1;
      ring_count++;
    endfunction

    function logic [JOB_ID_W-1:0] ring_pop();
      logic [JOB_ID_W-1:0] id;
      id = ring_ids[ring_head];
      ring_head = (ring_head + 1 >= NUM_JOBS) ? 0 : ring_head + 1;
      ring_count--;
      return id;
    endfunction

    function rsp_t schedule_step(req_t r);
      rsp_t                o;
      int unsigned         quantum;
      logic [LEN_W-1:0]    rem;
      logic [JOB_ID_W-1:0] id;
      bit                  fin;
      o = '0;
      if (r.action == ACT_CREATE) begin
        if (made >= NUM_JOBS) begin
          o.status = ST_FULL;
          return o;
        end
        id = JOB_ID_W'(made);
        made++;
        job_len[id]  = r.job_length;
        job_prog[id] = '0;
        job_fin[id]  = 1'b0;
        ring_push(id);
        o.status = ST_CREATED;
        o.job_id = id;
        return o;
      end
      quantum = (time_slice == 0) ? 1 : time_slice;
      if (cur_valid && !job_fin[cur_job] && slice_cnt < quantum) begin
        slice_cnt++;
      end else begin
        if (cur_valid && !job_fin[cur_job]) ring_push(cur_job);
        slice_cnt = '0;
        if (ring_count == 0) begin
          cur_valid = 1'b0;
          o.status  = ST_IDLE;
          return o;
        end
        cur_job   = ring_pop();
        cur_valid = 1'b1;
        slice_cnt = 8'd1;
      end
      id  = cur_job;
      rem = (job_len[id] > job_prog[id]) ? job_len[id] - job_prog[id] : '0;
      job_prog[id] = job_prog[id] + 1'b1;
      fin = (job_prog[id] >= job_len[id]);
      if (fin) begin
        job_fin[id] = 1'b1;
        cur_valid   = 1'b0;
      end
      o.status           = ST_RAN;
      o.job_id           = id;
      o.remaining_before = rem;
      o.slice_used       = slice_cnt;
      o.finished         = fin;
      return o;
    endfunction

    function void note_request(req_t r);
      due_results.push_back(schedule_step(r));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual 0x%h", $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("job_id", want.job_id, got.job_id);
      compare_field("remaining_before", want.remaining_before, got.remaining_before);
      compare_field("slice_used", want.slice_used, got.slice_used);
      compare_field("finished", want.finished, got.finished);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLICE_W-1:0] cfg_data;

  sched_scoreboard sb;
  bit              quiet        = 1'b0;
  bit              hold_off_req = 1'b0;
  int unsigned     cycles       = 0;

  round_robin_job_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        stall_left = pick_gap() - 1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  task automatic send_beat(logic action, logic [LEN_W-1:0] len);
    req_t        r;
    int unsigned gap;
    r.action     = action;
    r.job_length = len;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_slice(v);
  endtask

  initial begin
    logic [SLICE_W-1:0] slices[7];
    logic [LEN_W-1:0]   len;
    bit                 make;
    int unsigned        r;
    sb = new();
    slices = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd0, 8'd6};
    slices[5] = SLICE_W'($urandom_range(0, 255));
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_beat(ACT_TICK, 16'h0000);
    send_beat(ACT_CREATE, 16'h0000);
    send_beat(ACT_TICK, 16'hFFFF);
    send_beat(ACT_TICK, 16'h0000);
    send_beat(ACT_CREATE, 16'hFFFF);
    send_beat(ACT_CREATE, 16'h0001);
    send_beat(ACT_CREATE, 16'h0003);
    repeat (6) send_beat(ACT_TICK, 16'h0000);
    write_slice(8'd0);
    repeat (4) send_beat(ACT_TICK, 16'h0000);
    write_slice(8'd255);
    repeat (3) send_beat(ACT_TICK, 16'h0000);

    for (int p = 0; p < 7; p++) begin
      write_slice(slices[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (p == 3) || ((p == 1 || p == 4) && n >= 60 && n < 80);
        if ((p == 1 || p == 4) && n == 60) hold_off_req = 1'b1;
        if (n == 120) wait_drained();
        if (sb.jobs_made() < NUM_JOBS) make = ($urandom_range(0, 23) == 0);
        else make = ($urandom_range(0, 15) == 0);
        len = LEN_W'($urandom_range(0, 65535));
        if (make && sb.jobs_made() < NUM_JOBS) begin
          r = $urandom_range(0, 15);
          if (r == 0) len = '0;
          else if (r != 1) len = LEN_W'($urandom_range(1, 40));
        end
        send_beat(make ? ACT_CREATE : ACT_TICK, len);
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
